// ----- hw/rtl/ffht_pkg.sv -----
// Shared constants, types and codes for the first-fit hole table allocator.
package ffht_pkg;

    localparam int ENTRIES   = 64;
    localparam int ADDR_W    = 32;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int LINK_W    = $clog2(ENTRIES + 1);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int CFG_IDX_W = 8;

    localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(ENTRIES);

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_HOLE = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LENGTH = CFG_IDX_W'(1);

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic [LINK_W-1:0] link;
    } t_hole;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        t_hole             data;
    } t_wr;

    typedef struct packed {
        logic [ADDR_W-1:0] granted;
        logic [1:0]        status;
        logic [CNT_W-1:0]  count;
    } t_res;

endpackage

// ----- hw/rtl/ffht_mem.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
module ffht_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ffht_ctrl.sv -----
// Sequencer: table init sweep, first-fit walk, ordered insert and merge.
module ffht_ctrl
    import ffht_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_init,
    input  logic [ADDR_W-1:0] i_heap_start,
    input  logic [ADDR_W-1:0] i_heap_length,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [ADDR_W-1:0] i_block_base,
    input  logic [ADDR_W-1:0] i_request_size,
    input  logic              i_slot_free,
    output logic              o_res_valid,
    output t_res              o_res,
    output t_wr               o_wr,
    output logic [IDX_W-1:0]  o_raddr,
    input  t_hole             i_rdata
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_A_CHK  = 4'd2;
    localparam logic [3:0] S_A_DROP = 4'd3;
    localparam logic [3:0] S_R_SP   = 4'd4;
    localparam logic [3:0] S_R_WALK = 4'd5;
    localparam logic [3:0] S_J_RD   = 4'd6;
    localparam logic [3:0] S_J_CHK  = 4'd7;
    localparam logic [3:0] S_J_FIN  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [3:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_ic, n_ic;
    logic [LINK_W-1:0] r_head, n_head;
    logic [LINK_W-1:0] r_spare, n_spare;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [ADDR_W-1:0] r_req, n_req;
    logic [LINK_W-1:0] r_h, n_h;
    logic [LINK_W-1:0] r_prev, n_prev;
    logic [LINK_W-1:0] r_n, n_n;
    logic [LINK_W-1:0] r_xa, n_xa;
    logic [1:0]        r_pass, n_pass;
    t_hole             r_p, n_p;
    t_hole             r_x, n_x;
    logic [ADDR_W-1:0] r_granted, n_granted;
    logic [1:0]        r_status, n_status;

    logic [ADDR_W-1:0] rem;

    always_comb begin
        n_state   = r_state;
        n_ic      = r_ic;
        n_head    = r_head;
        n_spare   = r_spare;
        n_count   = r_count;
        n_base    = r_base;
        n_req     = r_req;
        n_h       = r_h;
        n_prev    = r_prev;
        n_n       = r_n;
        n_xa      = r_xa;
        n_pass    = r_pass;
        n_p       = r_p;
        n_x       = r_x;
        n_granted = r_granted;
        n_status  = r_status;
        o_wr      = '0;
        o_raddr   = '0;
        o_res_valid = 1'b0;
        rem       = i_rdata.size - r_req;

        case (r_state)
            S_INIT: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_ic;
                if (r_ic == '0) begin
                    o_wr.data = '{start: i_heap_start, size: i_heap_length, link: NO_LINK};
                end else begin
                    o_wr.data.start = '0;
                    o_wr.data.size  = '0;
                    o_wr.data.link  = (r_ic == LAST_IDX) ? NO_LINK
                                                         : LINK_W'(r_ic) + LINK_W'(1);
                end
                n_ic = r_ic + IDX_W'(1);
                if (r_ic == LAST_IDX) begin
                    n_head  = '0;
                    n_spare = LINK_W'(1);
                    n_count = CNT_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_base    = i_block_base;
                    n_req     = i_request_size;
                    n_granted = '0;
                    n_status  = STAT_OK;
                    n_prev    = NO_LINK;
                    if (i_kind == KIND_ALLOC) begin
                        if (r_head == NO_LINK) begin
                            n_status = STAT_NO_HOLE;
                            n_state  = S_DONE;
                        end else begin
                            o_raddr = r_head[IDX_W-1:0];
                            n_h     = r_head;
                            n_state = S_A_CHK;
                        end
                    end else if (i_request_size == '0) begin
                        n_state = S_DONE;
                    end else if (r_spare == NO_LINK) begin
                        n_status = STAT_FULL;
                        n_state  = S_DONE;
                    end else begin
                        o_raddr = r_spare[IDX_W-1:0];
                        n_n     = r_spare;
                        n_state = S_R_SP;
                    end
                end
            end
            S_A_CHK: begin
                if (i_rdata.size >= r_req) begin
                    n_granted = i_rdata.start;
                    if (rem == '0) begin
                        if (r_prev == NO_LINK) begin
                            n_head = i_rdata.link;
                        end else begin
                            o_wr.en   = 1'b1;
                            o_wr.addr = r_prev[IDX_W-1:0];
                            o_wr.data = '{start: r_p.start, size: r_p.size, link: i_rdata.link};
                        end
                        n_x     = '{start: i_rdata.start + r_req, size: '0, link: i_rdata.link};
                        n_state = S_A_DROP;
                    end else begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = r_h[IDX_W-1:0];
                        o_wr.data = '{start: i_rdata.start + r_req, size: rem,
                                      link: i_rdata.link};
                        n_state   = S_DONE;
                    end
                end else if (i_rdata.link == NO_LINK) begin
                    n_status = STAT_NO_HOLE;
                    n_state  = S_DONE;
                end else begin
                    n_prev  = r_h;
                    n_p     = i_rdata;
                    n_h     = i_rdata.link;
                    o_raddr = i_rdata.link[IDX_W-1:0];
                end
            end
            S_A_DROP: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_h[IDX_W-1:0];
                o_wr.data = '{start: r_x.start, size: r_x.size, link: r_spare};
                n_spare   = r_h;
                n_count   = r_count - CNT_W'(1);
                n_state   = S_DONE;
            end
            S_R_SP: begin
                n_spare = i_rdata.link;
                n_count = r_count + CNT_W'(1);
                n_pass  = '0;
                if (r_head == NO_LINK) begin
                    n_x     = '{start: r_base, size: r_req, link: NO_LINK};
                    n_xa    = r_n;
                    n_head  = r_n;
                    n_state = S_J_RD;
                end else begin
                    o_raddr = r_head[IDX_W-1:0];
                    n_h     = r_head;
                    n_state = S_R_WALK;
                end
            end
            S_R_WALK: begin
                if (r_base > i_rdata.start) begin
                    if (i_rdata.link == NO_LINK) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = r_n[IDX_W-1:0];
                        o_wr.data = '{start: r_base, size: r_req, link: NO_LINK};
                        n_x     = '{start: i_rdata.start, size: i_rdata.size, link: r_n};
                        n_xa    = r_h;
                        n_state = S_J_RD;
                    end else begin
                        n_prev  = r_h;
                        n_p     = i_rdata;
                        n_h     = i_rdata.link;
                        o_raddr = i_rdata.link[IDX_W-1:0];
                    end
                end else if (r_prev == NO_LINK) begin
                    n_x     = '{start: r_base, size: r_req, link: r_h};
                    n_xa    = r_n;
                    n_head  = r_n;
                    n_state = S_J_RD;
                end else begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_n[IDX_W-1:0];
                    o_wr.data = '{start: r_base, size: r_req, link: r_p.link};
                    n_x     = '{start: r_p.start, size: r_p.size, link: r_n};
                    n_xa    = r_prev;
                    n_state = S_J_RD;
                end
            end
            S_J_RD: begin
                if (r_pass == 2'd2 || r_x.link == NO_LINK) begin
                    n_state = S_J_FIN;
                end else begin
                    o_raddr = r_x.link[IDX_W-1:0];
                    n_state = S_J_CHK;
                end
            end
            S_J_CHK: begin
                if (r_x.start + r_x.size == i_rdata.start) begin
                    n_x.size  = r_x.size + i_rdata.size;
                    n_x.link  = i_rdata.link;
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_x.link[IDX_W-1:0];
                    o_wr.data = '{start: i_rdata.start, size: i_rdata.size, link: r_spare};
                    n_spare   = r_x.link;
                    n_count   = r_count - CNT_W'(1);
                end else begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_xa[IDX_W-1:0];
                    o_wr.data = r_x;
                    n_x       = i_rdata;
                    n_xa      = r_x.link;
                end
                n_pass  = r_pass + 2'd1;
                n_state = S_J_RD;
            end
            S_J_FIN: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_xa[IDX_W-1:0];
                o_wr.data = r_x;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_slot_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_ic    = '0;
            end
        endcase

        if (i_init) begin
            n_state = S_INIT;
            n_ic    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ic    <= '0;
            r_head  <= '0;
            r_spare <= LINK_W'(1);
            r_count <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_ic    <= n_ic;
            r_head  <= n_head;
            r_spare <= n_spare;
            r_count <= n_count;
        end
        r_base    <= n_base;
        r_req     <= n_req;
        r_h       <= n_h;
        r_prev    <= n_prev;
        r_n       <= n_n;
        r_xa      <= n_xa;
        r_pass    <= n_pass;
        r_p       <= n_p;
        r_x       <= n_x;
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    // a pending rebuild wins over a new request
    assign o_ready = (r_state == S_IDLE) && !i_init;
    assign o_res   = '{granted: r_granted, status: r_status, count: r_count};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("hole count beyond table size");

    a_res_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_slot_free)
        else $error("result issued into a busy output slot");

    a_merge_has_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_J_CHK) |-> (r_x.link != NO_LINK))
        else $error("merge check without a successor");

    a_init_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT && r_ic == LAST_IDX && !i_init) |=>
            (r_state == S_IDLE && r_count == CNT_W'(1)))
        else $error("init sweep did not finish cleanly");

endmodule

// ----- hw/rtl/first_fit_hole_table_allocator_top.sv -----
// Top level of the first-fit hole table allocator.
//
// Request channel (i_valid/o_ready): i_kind selects allocate or release,
// i_block_base is the released block start, i_request_size the unit count.
// Result channel (o_valid/i_ready): one result transaction per request with
// o_granted_base, o_status (ok / no hole / table full) and o_hole_count.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 sets the
// heap start, index 1 the heap length; either rebuilds the hole table.
// Other indexes are ignored.
// Operation: hole entries sit in one RAM with a registered read, and the
// list walks make one table hop per cycle. An allocate walks the hole list
// to the first hole that fits; a release walks to its ordered insert point
// and then merges with its neighbours.
// After reset the table is rebuilt by a sweep, one entry per cycle; a
// config write is registered before the sweep restarts. No request
// is taken until the sweep is done.
// A finished result sits in the output register; the next request is taken
// meanwhile, and its result waits until the receiver drains the first one.
module first_fit_hole_table_allocator_top
    import ffht_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic [ADDR_W-1:0]    i_block_base,
    input  logic [ADDR_W-1:0]    i_request_size,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ADDR_W-1:0]    o_granted_base,
    output logic [1:0]           o_status,
    output logic [CNT_W-1:0]     o_hole_count
);

    logic [ADDR_W-1:0] r_heap_start;
    logic [ADDR_W-1:0] r_heap_length;
    logic              r_init;
    logic              cfg_hit;

    // output slot
    logic              r_ovalid;
    t_res              r_out;

    logic              slot_free;
    logic              res_valid;
    t_res              res;
    t_wr               wr;
    logic [IDX_W-1:0]  raddr;
    logic [$bits(t_hole)-1:0] rdata_raw;
    t_hole             rdata;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit = i_cfg_valid &&
                     (i_cfg_index == CFG_HEAP_START || i_cfg_index == CFG_HEAP_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_start  <= '0;
            r_heap_length <= '0;
            r_init        <= 1'b0;
        end else begin
            r_init <= cfg_hit;
            if (i_cfg_valid && i_cfg_index == CFG_HEAP_START) begin
                r_heap_start <= i_cfg_data[ADDR_W-1:0];
            end
            if (i_cfg_valid && i_cfg_index == CFG_HEAP_LENGTH) begin
                r_heap_length <= i_cfg_data[ADDR_W-1:0];
            end
        end
    end

    assign slot_free = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_granted_base = r_out.granted;
    assign o_status       = r_out.status;
    assign o_hole_count   = r_out.count;

    assign rdata = t_hole'(rdata_raw);

    ffht_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_init         (r_init),
        .i_heap_start   (r_heap_start),
        .i_heap_length  (r_heap_length),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_block_base   (i_block_base),
        .i_request_size (i_request_size),
        .i_slot_free    (slot_free),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .o_wr           (wr),
        .o_raddr        (raddr),
        .i_rdata        (rdata)
    );

    ffht_mem #(
        .DEPTH (ENTRIES),
        .WIDTH ($bits(t_hole))
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

endmodule
